FILE: rtl/core/pipct_pkg.sv
// ----------------------------------------------------------------------------
// pipct_pkg
// Shared types and constants for the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pipct_pkg;

  // Signed Q8.8 coordinates
  localparam int COORD_WIDTH = 16;

  // Vertex count saturates here; a polygon needs at least this many
  localparam logic [1:0] TALLY_MAX = 2'd3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          last_vertex;
  } in_word_t;

  typedef struct packed {
    logic inside_res;
    logic too_few_vertices;
  } out_word_t;

endpackage

FILE: rtl/core/pipct_edge_test.sv
// ----------------------------------------------------------------------------
// pipct_edge_test
// Tests edge A->B against the +x ray from Q, exact sign arithmetic.
// ----------------------------------------------------------------------------
module pipct_edge_test import pipct_pkg::*; (
  input  logic signed [COORD_WIDTH-1:0] qx_i,
  input  logic signed [COORD_WIDTH-1:0] qy_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  output logic                          cross_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic signed [DW-1:0] v1x, v1y, v2x, v2y;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [NW-1:0] t1_num;
  logic                 dy_pos, dy_zero, t1_ok, t2_pos, t2_le1;

  always_comb begin
    v1x = {qx_i[COORD_WIDTH-1], qx_i} - {ax_i[COORD_WIDTH-1], ax_i};
    v1y = {qy_i[COORD_WIDTH-1], qy_i} - {ay_i[COORD_WIDTH-1], ay_i};
    v2x = {bx_i[COORD_WIDTH-1], bx_i} - {ax_i[COORD_WIDTH-1], ax_i};
    v2y = {by_i[COORD_WIDTH-1], by_i} - {ay_i[COORD_WIDTH-1], ay_i};

    prod_a = v2x * v1y;
    prod_b = v2y * v1x;
    t1_num = {prod_a[PW-1], prod_a} - {prod_b[PW-1], prod_b};

    dy_pos  = ~v2y[DW-1];
    dy_zero = (v2y == '0);

    // t1 >= 0: numerator zero or same sign as dy
    t1_ok  = (t1_num == '0) || (t1_num[NW-1] != dy_pos);
    // t2 > 0: v1y nonzero and same sign as dy
    t2_pos = (v1y != '0) && (v1y[DW-1] != dy_pos);
    // t2 <= 1
    t2_le1 = dy_pos ? (v1y <= v2y) : (v1y >= v2y);

    cross_o = ~dy_zero & t1_ok & t2_pos & t2_le1;
  end

endmodule

FILE: rtl/core/point_in_polygon_crossing_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Even-odd ray-casting point-in-polygon test, one vertex word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): one word per polygon
//   vertex in boundary order, each carrying the query point; last_vertex
//   closes the polygon. Output channel (out_valid_o / out_stall_i /
//   out_word_o): one word per polygon, issued for the last vertex only.
//   Throughput: one vertex per cycle while in_stall_o is low. Each word is
//   registered in the input register; both edge tests (previous and
//   closing edge), their products and the parity update sit between that
//   register and the result register.
//   Reset: tally, parity and both pipeline valids clear; the block accepts
//   words as soon as reset is released.
//   Receiver stall: a pending result holds in the output register. Non-last
//   vertices keep flowing; a last vertex waits in the input register, with
//   in_stall_o raised, until the output register frees.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test import pipct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  // Input register
  logic     s1_valid_q;
  in_word_t s1_q;

  // Polygon state
  logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_WIDTH-1:0] first_x_eff, first_y_eff;
  logic [1:0] tally_q, tally_d;
  logic       parity_q, parity_d;

  // Result register
  logic      out_valid_q;
  out_word_t out_q, out_d;

  logic out_free, s1_go, s1_close;
  logic cross_prev, cross_close;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_go      = s1_valid_q & (~s1_q.last_vertex | out_free);
  assign s1_close   = s1_go & s1_q.last_vertex;
  assign in_stall_o = s1_valid_q & ~s1_go;

  // First vertex of a polygon closes against itself
  assign first_x_eff = (tally_q == '0) ? s1_q.vertex_x : first_x_q;
  assign first_y_eff = (tally_q == '0) ? s1_q.vertex_y : first_y_q;

  pipct_edge_test u_prev_edge (
    .qx_i    (s1_q.query_x),
    .qy_i    (s1_q.query_y),
    .ax_i    (prev_x_q),
    .ay_i    (prev_y_q),
    .bx_i    (s1_q.vertex_x),
    .by_i    (s1_q.vertex_y),
    .cross_o (cross_prev)
  );

  pipct_edge_test u_close_edge (
    .qx_i    (s1_q.query_x),
    .qy_i    (s1_q.query_y),
    .ax_i    (s1_q.vertex_x),
    .ay_i    (s1_q.vertex_y),
    .bx_i    (first_x_eff),
    .by_i    (first_y_eff),
    .cross_o (cross_close)
  );

  always_comb begin
    tally_d  = (tally_q == TALLY_MAX) ? TALLY_MAX : tally_q + 2'd1;
    // no previous edge on the first vertex
    parity_d = parity_q ^ ((tally_q != '0) & cross_prev);
    if (tally_d != TALLY_MAX) begin
      out_d.inside_res       = 1'b0;
      out_d.too_few_vertices = 1'b1;
    end else begin
      out_d.inside_res       = parity_d ^ cross_close;
      out_d.too_few_vertices = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_word_i;
    end
  end

  // Polygon state: returns to reset after each closed polygon
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q   <= '0;
      parity_q  <= 1'b0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else if (s1_go) begin
      if (s1_q.last_vertex) begin
        tally_q   <= '0;
        parity_q  <= 1'b0;
        first_x_q <= '0;
        first_y_q <= '0;
        prev_x_q  <= '0;
        prev_y_q  <= '0;
      end else begin
        tally_q  <= tally_d;
        parity_q <= parity_d;
        prev_x_q <= s1_q.vertex_x;
        prev_y_q <= s1_q.vertex_y;
        if (tally_q == '0) begin
          first_x_q <= s1_q.vertex_x;
          first_y_q <= s1_q.vertex_y;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_close) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  a_res_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.inside_res && out_word_o.too_few_vertices))
    else $error("inside and too-few both set");

  a_close_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_close |=> out_valid_o)
    else $error("closed polygon produced no result");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_close |=> (tally_q == '0) && !parity_q)
    else $error("polygon state not cleared after close");

  a_stall_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_q.last_vertex && out_valid_q)
    else $error("input stalled without a blocked result");

endmodule

FILE: sim/point_in_polygon_crossing_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test_test
// Self-checking bench for the even-odd ray-casting point-in-polygon block.
// Streams directed and random polygons through the vertex channel, predicts
// each verdict with an exact integer crossing test, and checks every result
// word against the oldest pending verdict. Both sides idle and stall at
// random; one phase holds the receiver off long enough to back up the input.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_test_test;
  import pipct_pkg::*;

  localparam int ITEM_GOAL    = 1500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_CAP   = 40;    // keep the log short on a broken build
  localparam int HOLDOFF_LEN  = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  point_in_polygon_crossing_test u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Predictor copy of the polygon state
  logic signed [COORD_WIDTH-1:0] poly_first_x, poly_first_y;
  logic signed [COORD_WIDTH-1:0] poly_prev_x, poly_prev_y;
  logic [1:0]                    poly_count;
  logic                          poly_parity;

  // Verdicts predicted but not yet seen on the output channel
  out_word_t pending_verdicts[$];

  int items_sent     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int holdoff_cycles = 0;   // set by a test, counted down by the receiver
  bit tx_quiet       = 1'b0; // sender offers back to back
  bit rx_quiet       = 1'b0; // receiver never stalls

  always #6 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("point_in_polygon_crossing_test: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < REPORT_CAP) $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Idle/stall run length: mostly none or short, now and then long
  function automatic int pick_run(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Exact ray test of edge a->b against +x ray from q. The divisions of the
  // float form become sign comparisons against dy; products fit in 64 bits.
  function automatic bit edge_hits(longint qx, longint qy, longint ax, longint ay,
                                   longint bx, longint by);
    longint v1x, v1y, v2x, v2y, lhs, rhs;
    bit     t1_ok, t2_pos, t2_le1;
    v1x = qx - ax;
    v1y = qy - ay;
    v2x = bx - ax;
    v2y = by - ay;
    if (v2y == 0) return 1'b0;   // parallel to the ray
    lhs = v2x * v1y;
    rhs = v2y * v1x;
    if (v2y > 0) begin
      t1_ok  = (lhs >= rhs);
      t2_pos = (v1y > 0);
      t2_le1 = (v1y <= v2y);
    end else begin
      t1_ok  = (lhs <= rhs);
      t2_pos = (v1y < 0);
      t2_le1 = (v1y >= v2y);
    end
    return t1_ok && t2_pos && t2_le1;
  endfunction

  task automatic clear_polygon();
    poly_first_x = '0;
    poly_first_y = '0;
    poly_prev_x  = '0;
    poly_prev_y  = '0;
    poly_count   = '0;
    poly_parity  = 1'b0;
  endtask

  // Advance the predictor by one accepted vertex word
  task automatic track_vertex(in_word_t w);
    out_word_t verdict;
    if (poly_count == '0) begin
      poly_first_x = w.vertex_x;
      poly_first_y = w.vertex_y;
    end else if (edge_hits(w.query_x, w.query_y, poly_prev_x, poly_prev_y,
                           w.vertex_x, w.vertex_y)) begin
      poly_parity = ~poly_parity;
    end
    poly_prev_x = w.vertex_x;
    poly_prev_y = w.vertex_y;
    if (poly_count != TALLY_MAX) poly_count = poly_count + 2'd1;
    if (w.last_vertex) begin
      // closing edge uses the query of the last word
      if (edge_hits(w.query_x, w.query_y, w.vertex_x, w.vertex_y,
                    poly_first_x, poly_first_y)) begin
        poly_parity = ~poly_parity;
      end
      verdict.too_few_vertices = (poly_count != TALLY_MAX);
      verdict.inside_res       = (poly_count == TALLY_MAX) && poly_parity;
      pending_verdicts.push_back(verdict);
      clear_polygon();
    end
  endtask

  // Offer one vertex word and hold it until accepted. Valid is left high on
  // return; the next call either lowers it for a gap or replaces the word.
  task automatic send_vertex(int qx, int qy, int vx, int vy, bit last);
    in_word_t w;
    int       gap;
    bit       stalled;
    w.query_x     = COORD_WIDTH'(qx);
    w.query_y     = COORD_WIDTH'(qy);
    w.vertex_x    = COORD_WIDTH'(vx);
    w.vertex_y    = COORD_WIDTH'(vy);
    w.last_vertex = last;
    gap = pick_run(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    // stall sampled mid-cycle, acceptance at the following edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    track_vertex(w);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted verdict has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_verdicts.size() != 0);
  endtask

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r == 2) return 0;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random polygon; fixed_len of zero picks a length. Grid style puts many
  // vertices level with the query and many flat edges; others spread wide.
  task automatic send_random_polygon(int fixed_len);
    int len, style, qx, qy, step, r, dx, dy, vx, vy;
    bit moving;
    r = $urandom_range(0, 99);
    if (fixed_len > 0) len = fixed_len;
    else if (r < 8)    len = $urandom_range(1, 2);
    else if (r < 92)   len = $urandom_range(3, 8);
    else               len = $urandom_range(9, 24);
    style  = $urandom_range(0, 2);
    moving = ($urandom_range(0, 9) == 0);
    step   = $urandom_range(1, 512);
    qx     = rand_coord();
    qy     = rand_coord();
    for (int k = 0; k < len; k++) begin
      if (moving && k > 0) begin
        dx = $urandom_range(0, 2);
        dy = $urandom_range(0, 2);
        qx = qx + (dx - 1) * step;
        qy = qy + (dy - 1) * step;
      end
      case (style)
        0: begin
          dx = $urandom_range(0, 6);
          dy = $urandom_range(0, 6);
          vx = qx + (dx - 3) * step;
          vy = qy + (dy - 3) * step;
        end
        1: begin
          vx = rand_coord();
          vy = rand_coord();
        end
        default: begin
          dx = $urandom_range(0, 4000);
          dy = $urandom_range(0, 4000);
          vx = qx + dx - 2000;
          vy = qy + dy - 2000;
        end
      endcase
      send_vertex(qx, qy, vx, vy, k == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall runs, a quiet mode, and a counted long hold-off
  // --------------------------------------------------------------------------
  initial begin : rx_pacing
    int run_left;
    out_stall_i = 1'b0;
    run_left    = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_cycles > 0) begin
        out_stall_i <= 1'b1;
        holdoff_cycles--;
        run_left = 0;
      end else if (rx_quiet) begin
        out_stall_i <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        run_left = pick_run(1'b0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: sample mid-cycle, take the word at the next edge
  // --------------------------------------------------------------------------
  initial begin : result_monitor
    logic      seen_valid, seen_stall;
    out_word_t seen_word, want;
    forever begin
      @(negedge clk_i);
      seen_valid = out_valid_o;
      seen_stall = out_stall_i;
      seen_word  = out_word_o;
      @(posedge clk_i);
      if (rst_ni === 1'b1 && seen_valid === 1'b1 && seen_stall === 1'b0) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result word %b with no verdict pending", seen_word));
        end else begin
          want = pending_verdicts.pop_front();
          if (seen_word.inside_res !== want.inside_res)
            report_mismatch($sformatf("inside_res: expected %b, got %b",
                                      want.inside_res, seen_word.inside_res));
          if (seen_word.too_few_vertices !== want.too_few_vertices)
            report_mismatch($sformatf("too_few_vertices: expected %b, got %b",
                                      want.too_few_vertices, seen_word.too_few_vertices));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // One- and two-vertex polygons, the two-vertex one straddling the ray
  task automatic test_too_few_vertices();
    send_vertex(0, 0, 32767, -32768, 1'b1);
    send_vertex(0, 0, 100, -100, 1'b0);
    send_vertex(0, 0, 100, 100, 1'b1);
  endtask

  // Coordinates at both ends of the range, query inside then at a corner
  task automatic test_extremes();
    send_vertex(0, 0, -32768, -32768, 1'b0);
    send_vertex(0, 0, 32767, -32768, 1'b0);
    send_vertex(0, 0, 0, 32767, 1'b1);
    send_vertex(-32768, 32767, -32768, -32768, 1'b0);
    send_vertex(-32768, 32767, 32767, -32768, 1'b0);
    send_vertex(-32768, 32767, 0, 32767, 1'b1);
  endtask

  // Square whose bottom and top edges lie parallel to the ray
  task automatic test_flat_edges();
    send_vertex(0, 0, -256, -256, 1'b0);
    send_vertex(0, 0, 256, -256, 1'b0);
    send_vertex(0, 0, 256, 256, 1'b0);
    send_vertex(0, 0, -256, 256, 1'b1);
  endtask

  // Vertex exactly on the ray, and query exactly on an edge
  task automatic test_boundary_hits();
    send_vertex(0, 0, 512, 0, 1'b0);
    send_vertex(0, 0, -256, 256, 1'b0);
    send_vertex(0, 0, -256, -256, 1'b1);
    send_vertex(0, 0, 0, -256, 1'b0);
    send_vertex(0, 0, 512, -256, 1'b0);
    send_vertex(0, 0, 512, 256, 1'b0);
    send_vertex(0, 0, 0, 256, 1'b1);
  endtask

  // Query changes from word to word inside one polygon
  task automatic test_query_moves();
    send_vertex(0, 0, -512, -512, 1'b0);
    send_vertex(1024, 0, 512, -512, 1'b0);
    send_vertex(-1024, 128, 0, 512, 1'b1);
  endtask

  // Hexagon: tally saturates, parity keeps going
  task automatic test_many_vertices();
    send_vertex(10, 20, 512, 0, 1'b0);
    send_vertex(10, 20, 256, 443, 1'b0);
    send_vertex(10, 20, -256, 443, 1'b0);
    send_vertex(10, 20, -512, 0, 1'b0);
    send_vertex(10, 20, -256, -443, 1'b0);
    send_vertex(10, 20, 256, -443, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Random tests
  // --------------------------------------------------------------------------

  // Receiver held off while triangles keep coming: output register fills,
  // a last vertex parks in the input register and the input stalls.
  task automatic test_holdoff();
    holdoff_cycles = HOLDOFF_LEN;
    tx_quiet = 1'b1;
    repeat (40) send_random_polygon(3);
    tx_quiet = 1'b0;
    settle();
  endtask

  // Back to back on both sides, no idling at all
  task automatic test_burst();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (40) send_random_polygon(0);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    settle();
  endtask

  // Bulk random polygons with random idling on both sides
  task automatic test_random_polygons();
    while (items_sent < ITEM_GOAL) send_random_polygon(0);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    clear_polygon();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_too_few_vertices();
    test_extremes();
    test_flat_edges();
    test_boundary_hits();
    test_query_moves();
    test_many_vertices();
    settle();
    test_holdoff();
    test_burst();
    test_random_polygons();

    // drain, then keep watching for any stray word
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("point_in_polygon_crossing_test: match");
    end else begin
      $display("point_in_polygon_crossing_test: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pipct_pkg.sv
rtl/core/pipct_edge_test.sv
rtl/core/point_in_polygon_crossing_test.sv
sim/point_in_polygon_crossing_test_test.sv
